// ===== design/xtea_pkg.sv =====
package xtea_pkg;

   localparam int unsigned WORD_W    = 32;
   localparam int unsigned KEY_WORDS = 4;
   localparam int unsigned KEY_SEL_W = 2;
   localparam int unsigned CSR_IDX_W = 3;

   // Key schedule constant and the shift for the second key select
   localparam logic [WORD_W-1:0] XTEA_DELTA = 32'h9E37_79B9;
   localparam int unsigned       KEY_SHIFT  = 11;

   // Direction codes
   localparam logic CMD_ENCRYPT = 1'b0;
   localparam logic CMD_DECRYPT = 1'b1;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD3 = 3'd3;

   // One block in flight
   typedef struct packed {
      logic              cmd;
      logic [WORD_W-1:0] half_a;
      logic [WORD_W-1:0] half_b;
   } blk_type;

   // Feistel function of one half-round; rk is sum plus the selected key word
   function automatic logic [WORD_W-1:0] xtea_mix(input logic [WORD_W-1:0] x,
                                                  input logic [WORD_W-1:0] rk);
      return (((x << 4) ^ (x >> 5)) + x) ^ rk;
   endfunction

endpackage

// ===== design/xtea_block_cipher_top.sv =====
// Channel  Direction  Handshake           Payload
// req      in         req_valid/req_stall req_cmd, req_half_a_in, req_half_b_in
// rsp      out        rsp_valid/rsp_stall rsp_half_a_out, rsp_half_b_out
// csr      in         csr_we              csr_index, csr_wdata (key words 0..3)
//
// One half-round per pipeline stage, 2*ROUND_COUNT stages; one beat enters
// every cycle while req_stall is low. Each stage holds its beat only while
// the stage after it is full and held, so bubbles are squeezed out and
// req_stall rises only with every stage full and rsp_stall high. Synchronous
// reset clears the valid bits and the key. The round sums are constants per
// stage; decrypt beats use the mirrored sum and key select of the same
// stage.
module xtea_block_cipher_top #(
   parameter int unsigned ROUND_COUNT = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_cmd,
   input  logic [xtea_pkg::WORD_W-1:0]         req_half_a_in,
   input  logic [xtea_pkg::WORD_W-1:0]         req_half_b_in,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [xtea_pkg::WORD_W-1:0]         rsp_half_a_out,
   output logic [xtea_pkg::WORD_W-1:0]         rsp_half_b_out,
   input  logic                                csr_we,
   input  logic [xtea_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [xtea_pkg::WORD_W-1:0]         csr_wdata
);
   import xtea_pkg::*;

   localparam int unsigned STAGE_CNT = 2 * ROUND_COUNT;

   logic [WORD_W-1:0]  key_ff [KEY_WORDS];
   logic [STAGE_CNT-1:0] vld_ff;
   logic [STAGE_CNT-1:0] adv;
   blk_type            blk_ff  [STAGE_CNT];
   blk_type            blk_in  [STAGE_CNT];
   blk_type            stg_src [STAGE_CNT];

   // Key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < KEY_WORDS; k++) begin
            key_ff[k] <= '0;
         end
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_KEY_WORD0: key_ff[0] <= csr_wdata;
            CSR_KEY_WORD1: key_ff[1] <= csr_wdata;
            CSR_KEY_WORD2: key_ff[2] <= csr_wdata;
            CSR_KEY_WORD3: key_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage advance: a stage loads when empty or when the next one moves
   always_comb begin
      adv[STAGE_CNT-1] = !vld_ff[STAGE_CNT-1] || !rsp_stall;
      for (int s = STAGE_CNT - 2; s >= 0; s--) begin
         adv[s] = !vld_ff[s] || adv[s+1];
      end
   end

   assign req_stall = !adv[0];

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int s = 1; s < STAGE_CNT; s++) begin
            if (adv[s]) begin
               vld_ff[s] <= vld_ff[s-1];
            end
         end
      end
   end

   assign stg_src[0] = '{cmd: req_cmd, half_a: req_half_a_in, half_b: req_half_b_in};

   for (genvar s = 0; s < STAGE_CNT; s++) begin : g_stage
      // Sum after (s+1)/2 steps of delta, forward or from the top
      localparam int unsigned HALF_IDX = (s + 1) / 2;
      localparam logic [WORD_W-1:0] ENC_SUM =
         WORD_W'(64'(HALF_IDX) * 64'(XTEA_DELTA));
      localparam logic [WORD_W-1:0] DEC_SUM =
         WORD_W'(64'(ROUND_COUNT - HALF_IDX) * 64'(XTEA_DELTA));
      localparam bit EVEN = (s % 2) == 0;
      // Even encrypt and odd decrypt stages update half a, keyed by the low bits
      localparam logic [KEY_SEL_W-1:0] ENC_SEL =
         EVEN ? ENC_SUM[KEY_SEL_W-1:0] : ENC_SUM[KEY_SHIFT +: KEY_SEL_W];
      localparam logic [KEY_SEL_W-1:0] DEC_SEL =
         EVEN ? DEC_SUM[KEY_SHIFT +: KEY_SEL_W] : DEC_SUM[KEY_SEL_W-1:0];

      logic              upd_a;
      logic [WORD_W-1:0] x;
      logic [WORD_W-1:0] tgt;
      logic [WORD_W-1:0] rk;
      logic [WORD_W-1:0] mix_val;
      logic [WORD_W-1:0] new_val;

      if (s > 0) begin : g_link
         assign stg_src[s] = blk_ff[s-1];
      end

      // One half-round
      always_comb begin
         upd_a   = EVEN ^ (stg_src[s].cmd == CMD_DECRYPT);
         x       = upd_a ? stg_src[s].half_b : stg_src[s].half_a;
         tgt     = upd_a ? stg_src[s].half_a : stg_src[s].half_b;
         rk      = (stg_src[s].cmd == CMD_DECRYPT) ? (DEC_SUM + key_ff[DEC_SEL])
                                                  : (ENC_SUM + key_ff[ENC_SEL]);
         mix_val = xtea_mix(x, rk);
         new_val = (stg_src[s].cmd == CMD_DECRYPT) ? (tgt - mix_val) : (tgt + mix_val);
         blk_in[s]     = stg_src[s];
         if (upd_a) begin
            blk_in[s].half_a = new_val;
         end else begin
            blk_in[s].half_b = new_val;
         end
      end

      // Stage payload
      always_ff @(posedge clock) begin
         if (adv[s]) begin
            blk_ff[s] <= blk_in[s];
         end
      end
   end

   assign rsp_valid      = vld_ff[STAGE_CNT-1];
   assign rsp_half_a_out = blk_ff[STAGE_CNT-1].half_a;
   assign rsp_half_b_out = blk_ff[STAGE_CNT-1].half_b;

   // An accepted beat lands in the first stage
   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> vld_ff[0])
      else $error("accepted beat missing from first stage");

   // Input is held back only when every stage is full and the output is held
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&vld_ff) && rsp_stall)
      else $error("input stalled with room in the pipeline");

   // A write to key word 0 takes effect on the next cycle
   a_key0_write: assert property (@(posedge clock) disable iff (reset)
      csr_we && csr_index == CSR_KEY_WORD0 |=> key_ff[0] == $past(csr_wdata))
      else $error("key word 0 write lost");

endmodule

// ===== bench/tb_xtea_block_cipher_top.sv =====
module tb_xtea_block_cipher_top;
   timeunit 1ns;
   timeprecision 1ps;

   import xtea_pkg::*;

   localparam int unsigned ROUNDS      = 32;
   localparam int unsigned LATENCY     = 2 * ROUNDS;
   localparam int unsigned HOLD_CYCLES = 400;
   localparam int unsigned MAX_REPORTS = 10;
   localparam longint unsigned TIMEOUT_NS = 5_000_000;

   typedef logic [WORD_W-1:0] word_type;

   typedef struct packed {
      word_type half_a;
      word_type half_b;
   } block_type;

   // csr indexes of the key words, in key order
   localparam logic [CSR_IDX_W-1:0] KEY_CSR [KEY_WORDS] =
      '{CSR_KEY_WORD0, CSR_KEY_WORD1, CSR_KEY_WORD2, CSR_KEY_WORD3};
   // indexes past the key words, which must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_UNUSED = CSR_IDX_W'(KEY_WORDS);
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_UNUSED  = '1;

   logic                 clock;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   logic                 req_stall;
   logic                 req_cmd        = CMD_ENCRYPT;
   word_type             req_half_a_in  = '0;
   word_type             req_half_b_in  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall      = 1'b0;
   word_type             rsp_half_a_out;
   word_type             rsp_half_b_out;
   logic                 csr_we         = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index      = CSR_KEY_WORD0;
   word_type             csr_wdata      = '0;

   // key as the block should hold it; matches the reset value
   word_type  key_model [KEY_WORDS] = '{default: '0};
   block_type expected_blocks [$];
   int        error_count   = 0;
   int        send_idle_pct = 0;
   int        recv_idle_pct = 0;
   logic      rsp_hold      = 1'b0;

   xtea_block_cipher_top #(
      .ROUND_COUNT (ROUNDS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_half_a_in  (req_half_a_in),
      .req_half_b_in  (req_half_b_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_half_a_out (rsp_half_a_out),
      .rsp_half_b_out (rsp_half_b_out),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Shift/xor/add core of one half-round, before the round key is applied
   function automatic word_type feistel(input word_type x);
      return ((x << 4) ^ (x >> 5)) + x;
   endfunction

   // Full 32-round XTEA on one block with the current key
   function automatic block_type xtea_predict(input logic cmd, input word_type a,
                                              input word_type b);
      word_type y;
      word_type z;
      word_type sum;
      int       r;
      y = a;
      z = b;
      if (cmd == CMD_DECRYPT) begin
         sum = word_type'(XTEA_DELTA * ROUNDS);
         for (r = 0; r < ROUNDS; r++) begin
            z -= feistel(y) ^ (sum + key_model[sum[KEY_SHIFT +: KEY_SEL_W]]);
            sum -= XTEA_DELTA;
            y -= feistel(z) ^ (sum + key_model[sum[KEY_SEL_W-1:0]]);
         end
      end else begin
         sum = '0;
         for (r = 0; r < ROUNDS; r++) begin
            y += feistel(z) ^ (sum + key_model[sum[KEY_SEL_W-1:0]]);
            sum += XTEA_DELTA;
            z += feistel(y) ^ (sum + key_model[sum[KEY_SHIFT +: KEY_SEL_W]]);
         end
      end
      return '{half_a: y, half_b: z};
   endfunction

   // Result side stall: random, or forced high during a hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= rsp_hold || ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Compare each result beat with the oldest expected block
   always @(posedge clock) begin
      block_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_blocks.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("unexpected result beat: a=%h b=%h", rsp_half_a_out, rsp_half_b_out);
         end else begin
            want = expected_blocks.pop_front();
            if (rsp_half_a_out !== want.half_a || rsp_half_b_out !== want.half_b) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("block mismatch: expected a=%h b=%h, got a=%h b=%h",
                           want.half_a, want.half_b, rsp_half_a_out, rsp_half_b_out);
            end
         end
      end
   end

   // Offer one block, with random idle cycles ahead of it, until it is taken
   task automatic send_block(input logic cmd, input word_type a, input word_type b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_half_a_in <= a;
      req_half_b_in <= b;
      do @(posedge clock); while (req_stall);
      expected_blocks.insert(expected_blocks.size(), xtea_predict(cmd, a, b));
   endtask

   task automatic send_random_block();
      send_block($urandom_range(1) ? CMD_DECRYPT : CMD_ENCRYPT, $urandom, $urandom);
   endtask

   // Stop offering and let every block in flight come out
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_blocks.size() != 0) @(posedge clock);
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct <= recv_pct;
   endtask

   // Load all four key words, then poke an unused index with junk
   task automatic program_key(input word_type k0, input word_type k1, input word_type k2,
                              input word_type k3);
      word_type words [KEY_WORDS];
      int       i;
      words = '{k0, k1, k2, k3};
      for (i = 0; i < KEY_WORDS; i++) begin
         csr_we    <= 1'b1;
         csr_index <= KEY_CSR[i];
         csr_wdata <= words[i];
         @(posedge clock);
         key_model[i] = words[i];
      end
      csr_index <= CSR_IDX_W'($urandom_range(CSR_LAST_UNUSED, CSR_FIRST_UNUSED));
      csr_wdata <= $urandom;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Both directions on extreme blocks with the key left at reset
   task automatic test_reset_key();
      set_idling(0, 0);
      send_block(CMD_ENCRYPT, '0, '0);
      send_block(CMD_ENCRYPT, '1, '1);
      send_block(CMD_DECRYPT, '0, '0);
      send_block(CMD_DECRYPT, '1, '1);
      send_block(CMD_ENCRYPT, '0, '1);
      send_block(CMD_DECRYPT, '1, '0);
      wait_drained();
   endtask

   // All-ones key, then four distinct words so a wrong key select shows
   task automatic test_key_extremes();
      program_key('1, '1, '1, '1);
      send_block(CMD_ENCRYPT, '0, '0);
      send_block(CMD_DECRYPT, '1, '1);
      wait_drained();
      program_key('0, '1, 32'hAAAA_AAAA, 32'h5555_5555);
      send_block(CMD_ENCRYPT, 32'hAAAA_AAAA, 32'h5555_5555);
      send_block(CMD_DECRYPT, 32'h8000_0000, 32'h0000_0001);
      wait_drained();
   endtask

   // Decrypting a ciphertext must give back the plaintext
   task automatic test_round_trip();
      block_type plain;
      block_type cipher;
      int        n;
      program_key($urandom, $urandom, $urandom, $urandom);
      for (n = 0; n < 3; n++) begin
         plain  = '{half_a: $urandom, half_b: $urandom};
         cipher = xtea_predict(CMD_ENCRYPT, plain.half_a, plain.half_b);
         send_block(CMD_ENCRYPT, plain.half_a, plain.half_b);
         send_block(CMD_DECRYPT, cipher.half_a, cipher.half_b);
      end
      wait_drained();
   endtask

   // Random blocks under one idling mix, with a fresh random key
   task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
      int n;
      program_key($urandom, $urandom, $urandom, $urandom);
      set_idling(send_pct, recv_pct);
      for (n = 0; n < count; n++) send_random_block();
      wait_drained();
   endtask

   // Long result hold-off while blocks keep coming: the pipeline fills and
   // the request side must stall, then everything drains in order
   task automatic test_full_pipeline();
      int n;
      set_idling(0, 0);
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold <= 1'b0;
         end
      join_none
      for (n = 0; n < 2 * LATENCY + 32; n++) send_random_block();
      wait_drained();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_key();
      test_key_extremes();
      test_round_trip();
      test_random_traffic(150, 13, 78);
      test_random_traffic(150, 78, 13);
      test_random_traffic(150, 0, 0);
      test_full_pipeline();
      repeat (LATENCY + 8) @(posedge clock);
      if (error_count == 0 && expected_blocks.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== files.f =====
design/xtea_pkg.sv
design/xtea_block_cipher_top.sv
bench/tb_xtea_block_cipher_top.sv
